FILE: rtl/assert_macros.svh
// Assertion shorthands shared by the checker files.
// Each macro samples on the rising clock edge and is disabled while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define GBRB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define GBRB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gbrb_pkg.sv
// ----------------------------------------------------------------------------
// gbrb_pkg
// Shared widths, reset values and register indexes of the Gaussian blur core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gbrb_pkg;

  localparam int PIXEL_W        = 16;
  localparam int TAP_W          = 16;
  localparam int ROW_W          = 12;
  localparam int MAX_HEIGHT     = 4096;
  localparam int CFG_DATA_W     = 64;
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_RADIUS = 3;

  // Pixels times Q2.30 tap products: add half an LSB, then drop 30 fraction bits
  localparam int ROUND_SHIFT = 30;
  localparam int ROUND_HALF  = 1 << (ROUND_SHIFT - 1);

  localparam logic [1:0]            RESET_RADIUS = 2'd0;
  localparam logic [CFG_DATA_W-1:0] RESET_TAPS   = 64'd32768;
  localparam logic [8:0]            RESET_WIDTH  = 9'd256;
  localparam logic [12:0]           RESET_HEIGHT = 13'd256;

  typedef enum logic [1:0] {
    CFG_KERNEL_RADIUS = 2'd0,
    CFG_TAP_WEIGHTS   = 2'd1,
    CFG_FRAME_WIDTH   = 2'd2,
    CFG_FRAME_HEIGHT  = 2'd3
  } cfg_index_t;

endpackage

`default_nettype wire

FILE: rtl/gaussian_blur_replicate_border_core.sv
// ----------------------------------------------------------------------------
// gaussian_blur_replicate_border_core
// Sequence: each result that an accepted pixel releases is worked kernel row
//   by kernel row: S_ADDR reads, S_MUL and S_ACC run per tap, then S_ROW and
//   S_RACC weight the row; S_OUT hands the result over, waiting while stalled.
// Throughput: set by the single shared multiply-accumulate unit; no new pixel
//   is accepted until all its results are handed over; a pixel releasing nothing
//   leaves the core ready. Reset (synchronous, rst_n low) clears position,
//   control and registers to their defaults; the line store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gaussian_blur_replicate_border_core #(
  parameter int MAX_WIDTH  = gbrb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = gbrb_pkg::DEF_MAX_RADIUS
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input pixel stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [gbrb_pkg::PIXEL_W-1:0]        in_tdata,   // [15:0] pixel_value
  input  wire                                in_tuser,   // [0] frame_start
  // result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [gbrb_pkg::PIXEL_W-1:0]       out_tdata,  // [15:0] filtered_value
  output logic                               out_tlast,  // last_in_run
  output logic                               out_tuser,  // [0] frame_done
  // configuration writes
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [1:0]                          cfg_index,
  input  wire [gbrb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int PW     = gbrb_pkg::PIXEL_W;
  localparam int TW     = gbrb_pkg::TAP_W;
  localparam int ROW_W  = gbrb_pkg::ROW_W;
  localparam int NSLOT  = 2 * MAX_RADIUS + 1;        // rows held in the line store
  localparam int DEPTH  = NSLOT * MAX_WIDTH;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int SW     = $clog2(NSLOT);             // slot number and kernel index
  localparam int RW     = $clog2(MAX_RADIUS + 1);
  localparam int RSUM_W = PW + TW + SW;              // one kernel row of pixel*tap
  localparam int PROD_W = RSUM_W + TW;               // shared multiplier output
  localparam int ACC_W  = PROD_W + SW;               // whole window
  localparam int RQ_W   = ACC_W + 1 - gbrb_pkg::ROUND_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE,   // wait for a pixel
    S_ADDR,   // first read of a kernel row
    S_MUL,    // pixel times column tap
    S_ACC,    // add into the row sum, fetch the next pixel
    S_ROW,    // row sum times row tap
    S_RACC,   // add into the window sum
    S_OUT     // round, saturate, hand over the result
  } state_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t                 state_r,    state_nxt;
  logic [1:0]             rad_r,      rad_nxt;
  logic [gbrb_pkg::CFG_DATA_W-1:0] taps_r, taps_nxt;
  logic [8:0]             fw_r,       fw_nxt;
  logic [12:0]            fh_r,       fh_nxt;

  logic [ROW_W-1:0]       pos_row_r,  pos_row_nxt;   // position of the next pixel
  logic [CW-1:0]          pos_col_r,  pos_col_nxt;
  logic [SW-1:0]          pos_slot_r, pos_slot_nxt;
  logic [ROW_W-1:0]       in_row_r,   in_row_nxt;    // row of the pixel in work
  logic [SW-1:0]          in_slot_r,  in_slot_nxt;

  logic [ROW_W-1:0]       oi_r,       oi_nxt;        // result being computed
  logic [CW-1:0]          oj_r,       oj_nxt;
  logic [ROW_W-1:0]       i1_r,       i1_nxt;
  logic [CW-1:0]          j0_r,       j0_nxt;
  logic [CW-1:0]          j1_r,       j1_nxt;
  logic [SW-1:0]          ky_r,       ky_nxt;
  logic [SW-1:0]          kx_r,       kx_nxt;
  logic                   row_end_r,  row_end_nxt;

  logic [PROD_W-1:0]      prod_r,     prod_nxt;
  logic [RSUM_W-1:0]      rowsum_r,   rowsum_nxt;
  logic [ACC_W-1:0]       acc_r,      acc_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [PW-1:0]          out_data_r,  out_data_nxt;
  logic                   out_last_r,  out_last_nxt;
  logic                   out_done_r,  out_done_nxt;

  logic [PW-1:0]          mem [DEPTH];
  logic [PW-1:0]          rd_data_r;

  // --------------------------------------------------------------------------
  // Effective geometry: clamp the programmed values into range
  // --------------------------------------------------------------------------
  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_last;
  logic [RW-1:0]    rad_eff;
  logic [SW-1:0]    k_last;

  always_comb begin
    if (fw_r == '0) begin
      w_last = '0;
    end else if (int'(fw_r) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(int'(fw_r) - 1);
    end
    if (fh_r == '0) begin
      h_last = '0;
    end else if (int'(fh_r) > gbrb_pkg::MAX_HEIGHT) begin
      h_last = ROW_W'(gbrb_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = ROW_W'(int'(fh_r) - 1);
    end
  end

  assign rad_eff = (int'(rad_r) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_r);
  assign k_last  = SW'({rad_eff, 1'b0});

  // --------------------------------------------------------------------------
  // Accept side: place the pixel and work out which results it releases
  // --------------------------------------------------------------------------
  logic             in_fire;
  logic             restart;
  logic [ROW_W-1:0] cur_row, rad_row, i0;
  logic [CW-1:0]    cur_col, rad_col, j0, j1;
  logic [ROW_W-1:0] i1;
  logic [SW-1:0]    cur_slot;
  logic             rows_ok, cols_ok;
  logic [AW-1:0]    wr_addr;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // frame_start, or a position left outside a shrunken frame, restarts at (0,0)
  assign restart  = in_tuser || (pos_row_r > h_last) || (pos_col_r > w_last);
  assign cur_row  = restart ? '0 : pos_row_r;
  assign cur_col  = restart ? '0 : pos_col_r;
  assign cur_slot = restart ? '0 : pos_slot_r;
  assign wr_addr  = AW'(cur_slot) * AW'(MAX_WIDTH) + AW'(cur_col);

  assign rad_row = ROW_W'(rad_eff);
  assign rad_col = CW'(rad_eff);

  // last row or column releases everything up to the border; otherwise one
  // line lagging by the radius
  assign rows_ok = (cur_row == h_last) || (cur_row >= rad_row);
  assign i0      = (cur_row >= rad_row) ? cur_row - rad_row : '0;
  assign i1      = (cur_row == h_last) ? cur_row : i0;
  assign cols_ok = (cur_col == w_last) || (cur_col >= rad_col);
  assign j0      = (cur_col >= rad_col) ? cur_col - rad_col : '0;
  assign j1      = (cur_col == w_last) ? cur_col : j0;

  // --------------------------------------------------------------------------
  // Window read address with replicate borders
  // --------------------------------------------------------------------------
  logic signed [ROW_W+1:0] ys;
  logic signed [CW+1:0]    xs;
  logic [ROW_W-1:0]        y, d;
  logic [CW-1:0]           x;
  logic [SW-1:0]           slot_d, rd_slot;
  logic [AW-1:0]           rd_addr;

  always_comb begin
    ys = (ROW_W+2)'(oi_r) + (ROW_W+2)'(ky_r) - (ROW_W+2)'(rad_eff);
    if (ys[ROW_W+1]) begin
      y = '0;
    end else if (ys[ROW_W:0] > {1'b0, h_last}) begin
      y = h_last;
    end else begin
      y = ys[ROW_W-1:0];
    end
    xs = (CW+2)'(oj_r) + (CW+2)'(kx_r) - (CW+2)'(rad_eff);
    if (xs[CW+1]) begin
      x = '0;
    end else if (xs[CW:0] > {1'b0, w_last}) begin
      x = w_last;
    end else begin
      x = xs[CW-1:0];
    end
    // window rows sit at most 2R lines behind the pixel in work
    d      = in_row_r - y;
    slot_d = d[SW-1:0];
    if (in_slot_r >= slot_d) begin
      rd_slot = in_slot_r - slot_d;
    end else begin
      rd_slot = in_slot_r + SW'(NSLOT) - slot_d;
    end
    rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(x);
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: pixel * column tap, then row sum * row tap
  // --------------------------------------------------------------------------
  function automatic logic [TW-1:0] tap_sel(input logic [gbrb_pkg::CFG_DATA_W-1:0] taps,
                                            input logic [SW-1:0] k,
                                            input logic [RW-1:0] r);
    logic [SW-1:0] tap_off;
    tap_off = (k >= SW'(r)) ? k - SW'(r) : SW'(r) - k;
    return taps[{tap_off[1:0], 4'b0000} +: TW];
  endfunction

  logic [RSUM_W-1:0] mul_a;
  logic [TW-1:0]     mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    if (state_r == S_MUL) begin
      mul_a = RSUM_W'(rd_data_r);
      mul_b = tap_sel(taps_r, kx_r, rad_eff);
    end else begin
      mul_a = rowsum_r;
      mul_b = tap_sel(taps_r, ky_r, rad_eff);
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // round half up, drop the fraction, saturate to the pixel range
  logic [ACC_W:0]  rnd;
  logic [RQ_W-1:0] rnd_q;
  logic [PW-1:0]   sat_val;

  assign rnd     = {1'b0, acc_r} + (ACC_W+1)'(gbrb_pkg::ROUND_HALF);
  assign rnd_q   = rnd[ACC_W:gbrb_pkg::ROUND_SHIFT];
  assign sat_val = (|rnd_q[RQ_W-1:PW]) ? '1 : rnd_q[PW-1:0];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic res_last;

  assign res_last = (oi_r == i1_r) && (oj_r == j1_r);

  always_comb begin
    state_nxt     = state_r;
    rad_nxt       = rad_r;
    taps_nxt      = taps_r;
    fw_nxt        = fw_r;
    fh_nxt        = fh_r;
    pos_row_nxt   = pos_row_r;
    pos_col_nxt   = pos_col_r;
    pos_slot_nxt  = pos_slot_r;
    in_row_nxt    = in_row_r;
    in_slot_nxt   = in_slot_r;
    oi_nxt        = oi_r;
    oj_nxt        = oj_r;
    i1_nxt        = i1_r;
    j0_nxt        = j0_r;
    j1_nxt        = j1_r;
    ky_nxt        = ky_r;
    kx_nxt        = kx_r;
    row_end_nxt   = row_end_r;
    prod_nxt      = prod_r;
    rowsum_nxt    = rowsum_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;

    // configuration transaction
    if (cfg_valid) begin
      unique case (cfg_index)
        gbrb_pkg::CFG_KERNEL_RADIUS: rad_nxt  = cfg_data[1:0];
        gbrb_pkg::CFG_TAP_WEIGHTS:   taps_nxt = cfg_data;
        gbrb_pkg::CFG_FRAME_WIDTH:   fw_nxt   = cfg_data[8:0];
        gbrb_pkg::CFG_FRAME_HEIGHT:  fh_nxt   = cfg_data[12:0];
        default: ;
      endcase
    end

    // drop the result once the consumer has taken it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          in_row_nxt  = cur_row;
          in_slot_nxt = cur_slot;
          oi_nxt      = i0;
          oj_nxt      = j0;
          i1_nxt      = i1;
          j0_nxt      = j0;
          j1_nxt      = j1;
          ky_nxt      = '0;
          kx_nxt      = '0;
          rowsum_nxt  = '0;
          acc_nxt     = '0;
          // advance the raster position, wrapping at the frame end
          if (cur_col == w_last) begin
            pos_col_nxt = '0;
            if (cur_row == h_last) begin
              pos_row_nxt  = '0;
              pos_slot_nxt = '0;
            end else begin
              pos_row_nxt  = cur_row + 1'b1;
              pos_slot_nxt = (cur_slot == SW'(NSLOT - 1)) ? '0 : cur_slot + 1'b1;
            end
          end else begin
            pos_col_nxt  = cur_col + 1'b1;
            pos_row_nxt  = cur_row;
            pos_slot_nxt = cur_slot;
          end
          if (rows_ok && cols_ok) begin
            state_nxt = S_ADDR;
          end
        end
      end
      S_ADDR: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt    = mul_p;
        row_end_nxt = (kx_r == k_last);
        if (kx_r != k_last) begin
          kx_nxt = kx_r + 1'b1;
        end
        state_nxt = S_ACC;
      end
      S_ACC: begin
        rowsum_nxt = rowsum_r + RSUM_W'(prod_r);
        state_nxt  = row_end_r ? S_ROW : S_MUL;
      end
      S_ROW: begin
        prod_nxt  = mul_p;
        state_nxt = S_RACC;
      end
      S_RACC: begin
        acc_nxt    = acc_r + ACC_W'(prod_r);
        rowsum_nxt = '0;
        kx_nxt     = '0;
        if (ky_r == k_last) begin
          state_nxt = S_OUT;
        end else begin
          ky_nxt    = ky_r + 1'b1;
          state_nxt = S_ADDR;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = sat_val;
          out_last_nxt  = res_last;
          out_done_nxt  = (oi_r == h_last) && (oj_r == w_last);
          ky_nxt        = '0;
          kx_nxt        = '0;
          acc_nxt       = '0;
          if (res_last) begin
            state_nxt = S_IDLE;
          end else begin
            if (oj_r == j1_r) begin
              oj_nxt = j0_r;
              oi_nxt = oi_r + 1'b1;
            end else begin
              oj_nxt = oj_r + 1'b1;
            end
            state_nxt = S_ADDR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rad_r       <= gbrb_pkg::RESET_RADIUS;
      taps_r      <= gbrb_pkg::RESET_TAPS;
      fw_r        <= gbrb_pkg::RESET_WIDTH;
      fh_r        <= gbrb_pkg::RESET_HEIGHT;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      pos_slot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rad_r       <= rad_nxt;
      taps_r      <= taps_nxt;
      fw_r        <= fw_nxt;
      fh_r        <= fh_nxt;
      pos_row_r   <= pos_row_nxt;
      pos_col_r   <= pos_col_nxt;
      pos_slot_r  <= pos_slot_nxt;
      out_valid_r <= out_valid_nxt;
      in_row_r    <= in_row_nxt;
      in_slot_r   <= in_slot_nxt;
      oi_r        <= oi_nxt;
      oj_r        <= oj_nxt;
      i1_r        <= i1_nxt;
      j0_r        <= j0_nxt;
      j1_r        <= j1_nxt;
      ky_r        <= ky_nxt;
      kx_r        <= kx_nxt;
      row_end_r   <= row_end_nxt;
      prod_r      <= prod_nxt;
      rowsum_r    <= rowsum_nxt;
      acc_r       <= acc_nxt;
      out_data_r  <= out_data_nxt;
      out_last_r  <= out_last_nxt;
      out_done_r  <= out_done_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: one write port for the incoming pixel, one registered read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem[wr_addr] <= in_tdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;
  assign cfg_ready  = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/gbrb_checker.sv
// ----------------------------------------------------------------------------
// gbrb_checker
// Port-level checks of the Gaussian blur core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gbrb_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_tvalid,
  input wire                          in_tready,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [gbrb_pkg::PIXEL_W-1:0]  out_tdata,
  input wire                          out_tlast,
  input wire                          out_tuser
);

  // a stalled result keeps its payload
  `GBRB_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser),
    "stalled result changed")

  // the core only goes busy on an input transaction
  `GBRB_ASSERT_IMP(a_busy_on_accept, clk, rst_n, $fell(in_tready),
    $past(in_tvalid && in_tready), "ready dropped without an input transaction")

  // a fresh result is produced only while the input side is closed
  `GBRB_ASSERT_IMP(a_result_while_busy, clk, rst_n, $rose(out_tvalid),
    !$past(in_tready), "result appeared while idle")

  // the bottom-right pixel is always the last result of its pixel
  `GBRB_ASSERT_IMP(a_done_is_last, clk, rst_n, out_tvalid && out_tuser,
    out_tlast, "frame end not marked as last of run")

endmodule

bind gaussian_blur_replicate_border_core gbrb_checker u_gbrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
